// ===== rtl/core/epsm_pkg.sv =====
// Shared types and constants of the encoder period speed meter.
`timescale 1ns / 1ps

package epsm_pkg;

  // Fixed field and register widths.
  localparam int MODE_BITS      = 1;
  localparam int CHAN_BITS      = 2;
  localparam int THRESH_BITS    = 8;
  localparam int TIMEOUT_BITS   = 24;
  localparam int NUM_BITS       = 32;
  localparam int OUT_SPEED_BITS = 24;
  localparam int SHOWN          = 4;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIV_CNT_BITS   = $clog2(NUM_BITS);

  // Register reset values.
  localparam logic [THRESH_BITS-1:0]  THRESH_RST  = 8'd60;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 24'd500000;
  localparam logic [NUM_BITS-1:0]     NUM_RST     = 32'd282858800;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK = 1'b0,
    MODE_EDGE = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EDGE_THRESHOLD  = 2'd0,
    REG_TIMEOUT_TICKS   = 2'd1,
    REG_SPEED_NUMERATOR = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/epsm_item_if.sv =====
// Request channel carrying ticks and encoder edges.
`timescale 1ns / 1ps

interface epsm_item_if
  import epsm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;
  logic [CHAN_BITS-1:0] channel;

  modport source (output valid, output mode, output channel, input ready);
  modport sink   (input valid, input mode, input channel, output ready);
endinterface

// ===== rtl/core/epsm_result_if.sv =====
// Result channel carrying speeds and status.
`timescale 1ns / 1ps

interface epsm_result_if
  import epsm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OUT_SPEED_BITS-1:0] speed_ch0;
  logic [OUT_SPEED_BITS-1:0] speed_ch1;
  logic [OUT_SPEED_BITS-1:0] speed_ch2;
  logic [OUT_SPEED_BITS-1:0] speed_ch3;
  logic                      window_done;
  logic [SHOWN-1:0]          stopped_mask;

  modport source (output valid, output speed_ch0, output speed_ch1, output speed_ch2,
                  output speed_ch3, output window_done, output stopped_mask, input ready);
  modport sink   (input valid, input speed_ch0, input speed_ch1, input speed_ch2,
                  input speed_ch3, input window_done, input stopped_mask, output ready);
endinterface

// ===== rtl/core/epsm_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface epsm_cfg_if
  import epsm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/encoder_period_speed_meter.sv =====
// Top level of the encoder period speed meter.
`timescale 1ns / 1ps

// Four-channel (CHANNELS) encoder period speed meter.
// item:   one request per timebase tick (mode 0) or per rising encoder edge
//         (mode 1, channel selects the encoder). Taken only while idle.
// result: one request per item: all stored speeds, window_done and the
//         per-channel stopped mask, all as they stand after the item.
// cfg:    register writes (0 edge_threshold, 1 timeout_ticks,
//         2 speed_numerator); always ready, unknown indexes ignored.
// Timing: a sequencer walks the channels one per cycle, sharing one
//   subtract/compare unit between the timeout checks and a restoring
//   divider that yields one quotient bit per cycle.
//   Tick: channel scan, then finish. Edge closing no window or a zero-period
//   one: edge step, scan, finish. Edge that closes a window: edge step,
//   32 divide steps, scan, finish.
// Stall: the result sits in an output register; the block can take and
//   work the next item meanwhile, then waits before loading its own result.
// Reset (rst, synchronous): registers to reset values, all counts, timers
//   and speeds to zero, output empty.
module encoder_period_speed_meter
  import epsm_pkg::*;
#(
  parameter int CHANNELS   = 4,
  parameter int TIMER_BITS = 24,
  parameter int SPEED_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  epsm_item_if.sink     item,
  epsm_result_if.source result,
  epsm_cfg_if.sink      cfg
);

  localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CXW = (IW > CHAN_BITS) ? IW : CHAN_BITS;
  localparam int AW  = ((TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS) + 1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

  // Configuration registers
  logic [THRESH_BITS-1:0]  thresh;
  logic [TIMEOUT_BITS-1:0] timeout;
  logic [NUM_BITS-1:0]     numerator;

  // Channel state
  logic [THRESH_BITS-1:0] cnts [CHANNELS];
  logic [TIMER_BITS-1:0]  elap [CHANNELS];
  logic [SPEED_BITS-1:0]  spd  [CHANNELS];

  // Sequencer
  state_t                  state, state_next;
  logic                    is_tick;
  logic [IW-1:0]           chan_idx;
  logic [IW-1:0]           scan_idx;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [TIMER_BITS-1:0]   rem;
  logic [NUM_BITS-1:0]     quot;
  logic [TIMER_BITS-1:0]   period;
  logic                    done;
  logic [CHANNELS-1:0]     stop_bits;

  // Output register
  logic                      out_valid;
  logic [OUT_SPEED_BITS-1:0] out_speed [SHOWN];
  logic                      out_done;
  logic [SHOWN-1:0]          out_stop;

  // Datapath
  logic [IW-1:0]          rd_idx;
  logic [THRESH_BITS-1:0] rd_cnt;
  logic [TIMER_BITS-1:0]  rd_elap;
  logic [TIMER_BITS-1:0]  elap_inc;
  logic [TIMER_BITS-1:0]  scan_val;
  logic [TIMER_BITS:0]    trial;
  logic [AW-1:0]          alu_a, alu_b;
  logic [AW:0]            alu_diff;
  logic                   alu_ge;
  logic [NUM_BITS-1:0]    quot_next;
  logic [SPEED_BITS-1:0]  spd_q;
  logic [CXW-1:0]         ch_ext;
  logic                   ch_ok;
  logic                   closes;
  logic                   scan_last;
  logic                   out_free;

  // Write controls
  logic                   cnt_we, elap_we, spd_we;
  logic [THRESH_BITS-1:0] cnt_wd;
  logic [TIMER_BITS-1:0]  elap_wd;
  logic [SPEED_BITS-1:0]  spd_wd;

  logic [OUT_SPEED_BITS-1:0] show_speed [SHOWN];
  logic [SHOWN-1:0]          show_stop;

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign out_free   = !out_valid || result.ready;

  assign ch_ext = CXW'(item.channel);
  assign ch_ok  = (32'(item.channel) < CHANNELS);

  assign rd_idx   = (state == ST_SCAN) ? scan_idx : chan_idx;
  assign rd_cnt   = cnts[rd_idx];
  assign rd_elap  = elap[rd_idx];
  assign elap_inc = (rd_elap == TIMER_MAX) ? rd_elap : rd_elap + 1'b1;
  assign scan_val = is_tick ? elap_inc : rd_elap;
  assign closes   = !(rd_cnt < thresh);
  assign scan_last = (scan_idx == IW'(CHANNELS - 1));

  // Shared subtract/compare: divide step or timeout check
  assign trial    = {rem, quot[NUM_BITS-1]};
  assign alu_a    = (state == ST_DIV) ? AW'(trial) : AW'(scan_val);
  assign alu_b    = (state == ST_DIV) ? AW'(period) : AW'(timeout);
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[AW];

  assign quot_next = {quot[NUM_BITS-2:0], alu_ge};
  assign spd_q     = ((quot_next >> SPEED_BITS) != '0) ? SPEED_MAX : SPEED_BITS'(quot_next);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          if (mode_t'(item.mode) == MODE_EDGE && ch_ok) state_next = ST_EDGE;
          else state_next = ST_SCAN;
        end
      end
      ST_EDGE: begin
        if (!closes || rd_elap == '0) state_next = ST_SCAN;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Channel state write controls
  always_comb begin
    cnt_we  = 1'b0;
    elap_we = 1'b0;
    spd_we  = 1'b0;
    cnt_wd  = '0;
    elap_wd = '0;
    spd_wd  = '0;
    unique case (state)
      ST_EDGE: begin
        cnt_we = 1'b1;
        if (!closes) begin
          cnt_wd = rd_cnt + 1'b1;
        end else begin
          elap_we = 1'b1;
          if (rd_elap == '0) begin
            spd_we = 1'b1;
            spd_wd = SPEED_MAX;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          spd_we = 1'b1;
          spd_wd = spd_q;
        end
      end
      ST_SCAN: begin
        if (is_tick) begin
          elap_we = 1'b1;
          elap_wd = elap_inc;
          if (alu_ge) begin
            cnt_we = 1'b1;
            spd_we = 1'b1;
          end
        end
      end
      ST_IDLE, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh    <= THRESH_RST;
      timeout   <= TIMEOUT_RST;
      numerator <= NUM_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_EDGE_THRESHOLD:  thresh    <= THRESH_BITS'(cfg.data);
        REG_TIMEOUT_TICKS:   timeout   <= TIMEOUT_BITS'(cfg.data);
        REG_SPEED_NUMERATOR: numerator <= NUM_BITS'(cfg.data);
        default: ;
      endcase
    end
  end

  // Channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnts[i] <= '0;
        elap[i] <= '0;
        spd[i]  <= '0;
      end
    end else begin
      if (cnt_we)  cnts[rd_idx] <= cnt_wd;
      if (elap_we) elap[rd_idx] <= elap_wd;
      if (spd_we)  spd[rd_idx]  <= spd_wd;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      is_tick   <= 1'b0;
      scan_idx  <= '0;
      stop_bits <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && item.valid) begin
        is_tick  <= (mode_t'(item.mode) == MODE_TICK);
        chan_idx <= ch_ext[IW-1:0];
        done     <= 1'b0;
        scan_idx <= '0;
      end
      if (state == ST_EDGE && closes) begin
        done    <= 1'b1;
        period  <= rd_elap;
        rem     <= '0;
        quot    <= numerator;
        div_cnt <= DIV_CNT_BITS'(NUM_BITS - 1);
      end
      if (state == ST_DIV) begin
        rem     <= alu_ge ? alu_diff[TIMER_BITS-1:0] : trial[TIMER_BITS-1:0];
        quot    <= quot_next;
        div_cnt <= div_cnt - 1'b1;
      end
      if (state == ST_SCAN) begin
        stop_bits[scan_idx] <= alu_ge;
        if (!scan_last) scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // Channels shown on the result; absent ones read as zero
  for (genvar g = 0; g < SHOWN; g++) begin : g_show
    if (g < CHANNELS) begin : g_present
      assign show_speed[g] = OUT_SPEED_BITS'(spd[g]);
      assign show_stop[g]  = stop_bits[g];
    end else begin : g_absent
      assign show_speed[g] = '0;
      assign show_stop[g]  = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
        out_speed <= show_speed;
        out_done  <= done;
        out_stop  <= show_stop;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.speed_ch0    = out_speed[0];
  assign result.speed_ch1    = out_speed[1];
  assign result.speed_ch2    = out_speed[2];
  assign result.speed_ch3    = out_speed[3];
  assign result.window_done  = out_done;
  assign result.stopped_mask = out_stop;

endmodule

// ===== tb/tb_encoder_period_speed_meter.sv =====
// Self-checking testbench of the encoder period speed meter.
`timescale 1ns / 1ps

// Drives tick and edge requests through the item channel, register writes
// through the cfg channel, and checks every result request against a typed
// expectation or a cycle-free predictor of the meter that runs alongside.
//
// Flow:
//   1. reset
//   2. directed table: typed expectations where the answer is obvious,
//      predictor for the rest
//   3. random phases: new register settings per phase (block drained first),
//      then a mix of ticks and edges with random channel
// Sender runs in bursts with random gaps; receiver stalls on its own pattern
// and, once, holds off for a long stretch so the block backs up.
module tb_encoder_period_speed_meter;
  import epsm_pkg::*;

  localparam int CHANNELS     = 4;
  localparam int TIMER_BITS   = 24;
  localparam int SPEED_BITS   = 24;
  localparam int RANDOM_ITEMS = 1250;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = CHANNELS + 40;  // covers the longest item with margin
  localparam int CYCLE_LIMIT  = 1_000_000;

  // index 3 has no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam logic [SPEED_BITS-1:0] SPEED_FULL = '1;
  localparam logic [TIMER_BITS-1:0] TIMER_FULL = '1;

  // One result request as the block should present it.
  typedef struct packed {
    logic [OUT_SPEED_BITS-1:0] s0;
    logic [OUT_SPEED_BITS-1:0] s1;
    logic [OUT_SPEED_BITS-1:0] s2;
    logic [OUT_SPEED_BITS-1:0] s3;
    logic                      done;
    logic [SHOWN-1:0]          stopped;
  } speed_report_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,  // item request, expectation from the predictor
    ROW_TYPED,    // item request, expectation written in the table
    ROW_WRITE     // register write, taken with the block drained
  } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    mode_t                mode;
    logic [CHAN_BITS-1:0] chan;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0] data;
    speed_report_t        want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  epsm_item_if   item_ch ();
  epsm_result_if result_ch ();
  epsm_cfg_if    cfg_ch ();

  encoder_period_speed_meter #(
    .CHANNELS  (CHANNELS),
    .TIMER_BITS(TIMER_BITS),
    .SPEED_BITS(SPEED_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: register copies and per-channel meter state
  // ---------------------------------------------------------------------
  logic [THRESH_BITS-1:0]  thresh_reg  = THRESH_RST;
  logic [TIMEOUT_BITS-1:0] timeout_reg = TIMEOUT_RST;
  logic [NUM_BITS-1:0]     numer_reg   = NUM_RST;

  logic [7:0]            edge_tally  [CHANNELS] = '{default: '0};
  logic [TIMER_BITS-1:0] ticks_since [CHANNELS] = '{default: '0};
  logic [SPEED_BITS-1:0] held_speed  [CHANNELS] = '{default: '0};

  speed_report_t report_q [$];   // expected result requests, oldest first
  int fail_count = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;

  // long receiver hold-off: asked for by the main flow, taken by the receiver
  bit hold_request = 1'b0;
  bit hold_served  = 1'b0;

  function automatic void note_register(logic [CFG_IDX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] v);
    case (idx)
      REG_EDGE_THRESHOLD:  thresh_reg  = v[THRESH_BITS-1:0];
      REG_TIMEOUT_TICKS:   timeout_reg = v[TIMEOUT_BITS-1:0];
      REG_SPEED_NUMERATOR: numer_reg   = v[NUM_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advances the meter by one request and returns the report it should give.
  function automatic speed_report_t predict_report(mode_t m, logic [CHAN_BITS-1:0] ch);
    speed_report_t         r;
    logic [TIMER_BITS-1:0] period;
    logic [NUM_BITS-1:0]   quot;
    logic [SHOWN-1:0]      mask;
    r.done = 1'b0;
    if (m == MODE_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        // timer holds at full scale instead of wrapping
        if (ticks_since[c] != TIMER_FULL) ticks_since[c] = ticks_since[c] + 1'b1;
        if (ticks_since[c] >= timeout_reg) begin
          held_speed[c] = '0;
          edge_tally[c] = '0;
        end
      end
    end else if (edge_tally[ch] < thresh_reg) begin
      edge_tally[ch] = edge_tally[ch] + 1'b1;
    end else begin
      // window closes: period is the elapsed tick count
      period          = ticks_since[ch];
      edge_tally[ch]  = '0;
      ticks_since[ch] = '0;
      if (period == '0) begin
        held_speed[ch] = SPEED_FULL;
      end else begin
        quot = numer_reg / NUM_BITS'(period);
        held_speed[ch] = (quot > NUM_BITS'(SPEED_FULL)) ? SPEED_FULL
                                                         : quot[SPEED_BITS-1:0];
      end
      r.done = 1'b1;
    end
    mask = '0;
    for (int c = 0; c < CHANNELS; c++)
      if (ticks_since[c] >= timeout_reg) mask[c] = 1'b1;
    r.s0      = held_speed[0];
    r.s1      = held_speed[1];
    r.s2      = held_speed[2];
    r.s3      = held_speed[3];
    r.stopped = mask;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------
  function automatic plan_row_t step_row(mode_t m, logic [CHAN_BITS-1:0] ch);
    plan_row_t r;
    r = '{kind: ROW_PREDICT, mode: m, chan: ch, reg_idx: '0, data: '0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(mode_t m, logic [CHAN_BITS-1:0] ch,
                                          logic [23:0] s0, logic [23:0] s1,
                                          logic [23:0] s2, logic [23:0] s3,
                                          logic done, logic [3:0] stopped);
    plan_row_t r;
    r = step_row(m, ch);
    r.kind = ROW_TYPED;
    r.want = '{s0: s0, s1: s1, s2: s2, s3: s3, done: done, stopped: stopped};
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] v);
    plan_row_t r;
    r = step_row(MODE_TICK, '0);
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.data    = v;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driving tasks (all called at a rising edge)
  // ---------------------------------------------------------------------

  // Offers one request and waits for it to be taken. valid stays high so
  // a following request in the same burst goes out back to back.
  task automatic offer_request(mode_t m, logic [CHAN_BITS-1:0] ch, bit typed,
                               speed_report_t want);
    speed_report_t pred;
    item_ch.valid   <= 1'b1;
    item_ch.mode    <= m;
    item_ch.channel <= ch;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pred = predict_report(m, ch);
    report_q = {report_q, (typed ? want : pred)};
  endtask

  // Burst pacing: at the end of a burst drop valid for a random gap.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
      burst_left = $urandom_range(0, 23);
    end
  endtask

  // Stop sending and let every outstanding result drain before a write.
  task automatic settle_block();
    item_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write; valid drops once the write is taken and has reached
  // the channel before the task returns, so writes never lower and raise valid in the same step.
  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    note_register(idx, v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    speed_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %0h %0h %0h %0h %0h %0h",
                 $time, result_ch.speed_ch0, result_ch.speed_ch1, result_ch.speed_ch2,
                 result_ch.speed_ch3, result_ch.window_done, result_ch.stopped_mask);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        check_field("speed_ch0",    want.s0,      result_ch.speed_ch0);
        check_field("speed_ch1",    want.s1,      result_ch.speed_ch1);
        check_field("speed_ch2",    want.s2,      result_ch.speed_ch2);
        check_field("speed_ch3",    want.s3,      result_ch.speed_ch3);
        check_field("window_done",  want.done,    result_ch.window_done);
        check_field("stopped_mask", want.stopped, result_ch.stopped_mask);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stretches of steady stall rate, plus one long hold-off
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall_pct;
    int stretch;
    int hold_left;
    stall_pct = 0;
    stretch   = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(16, 128);
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            default: stall_pct = 70;
          endcase
        end
        stretch--;
        result_ch.ready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // cycle counter and watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("encoder_period_speed_meter test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------
  initial begin : main_flow
    plan_row_t     plan [$];
    speed_report_t blank;
    mode_t         m;
    int            random_sent;
    int            phase;
    int            tick_pct;
    int            n;

    blank       = '0;
    random_sent = 0;
    phase       = 0;

    item_ch.valid   <= 1'b0;
    item_ch.mode    <= MODE_TICK;
    item_ch.channel <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_EDGE_THRESHOLD;
    cfg_ch.data     <= '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Typed rows follow the state by hand:
    // after reset everything reads zero; with threshold 0 every edge closes
    // a window; numerator all ones over a small period saturates; a window
    // closing with no ticks gives full scale; timeout 3 stops channels on
    // the third tick; timeout 0 stops all on any tick.
    plan = '{
      typed_row(MODE_TICK, 2'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 4'h0),
      reg_row(REG_EDGE_THRESHOLD, 32'd0),
      reg_row(REG_TIMEOUT_TICKS, 32'd3),
      reg_row(REG_SPEED_NUMERATOR, 32'hFFFF_FFFF),
      // quotient too large, then zero period
      typed_row(MODE_EDGE, 2'd0, SPEED_FULL, 24'h0, 24'h0, 24'h0, 1'b1, 4'h0),
      typed_row(MODE_EDGE, 2'd0, SPEED_FULL, 24'h0, 24'h0, 24'h0, 1'b1, 4'h0),
      typed_row(MODE_TICK, 2'd0, SPEED_FULL, 24'h0, 24'h0, 24'h0, 1'b0, 4'h0),
      // channels 1..3 reach the timeout first, channel 0 one tick later
      typed_row(MODE_TICK, 2'd0, SPEED_FULL, 24'h0, 24'h0, 24'h0, 1'b0, 4'hE),
      typed_row(MODE_TICK, 2'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 4'hF),
      typed_row(MODE_EDGE, 2'd3, 24'h0, 24'h0, 24'h0, SPEED_FULL, 1'b1, 4'h7),
      reg_row(REG_SPEED_NUMERATOR, 32'd0),
      step_row(MODE_EDGE, 2'd1),
      reg_row(REG_SPARE, 32'hFFFF_FFFF),
      reg_row(REG_TIMEOUT_TICKS, 32'd0),
      typed_row(MODE_TICK, 2'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 4'hF),
      step_row(MODE_EDGE, 2'd2),
      reg_row(REG_TIMEOUT_TICKS, 32'(TIMER_FULL)),
      reg_row(REG_SPEED_NUMERATOR, 32'd1000),
      reg_row(REG_EDGE_THRESHOLD, 32'd2),
      step_row(MODE_EDGE, 2'd2),
      step_row(MODE_EDGE, 2'd2),
      step_row(MODE_TICK, 2'd1),
      step_row(MODE_TICK, 2'd2),
      step_row(MODE_TICK, 2'd3),
      step_row(MODE_EDGE, 2'd2),
      step_row(MODE_EDGE, 2'd1),
      reg_row(REG_EDGE_THRESHOLD, 32'd255),
      step_row(MODE_EDGE, 2'd3),
      step_row(MODE_TICK, 2'd0)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle_block();
        write_register(plan[i].reg_idx, plan[i].data);
      end else begin
        offer_request(plan[i].mode, plan[i].chan, plan[i].kind == ROW_TYPED,
                      plan[i].want);
        pace_sender();
      end
    end

    // Random phases. Each phase drains the block, loads a new setting
    // (extremes mixed with small, busy values) and then streams requests.
    while (random_sent < RANDOM_ITEMS) begin
      settle_block();
      case ($urandom_range(0, 5))
        0:       write_register(REG_EDGE_THRESHOLD, 32'd0);
        1:       write_register(REG_EDGE_THRESHOLD, 32'd255);
        default: write_register(REG_EDGE_THRESHOLD, $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       write_register(REG_TIMEOUT_TICKS, 32'd1);
        1:       write_register(REG_TIMEOUT_TICKS, 32'(TIMER_FULL));
        default: write_register(REG_TIMEOUT_TICKS, $urandom_range(4, 80));
      endcase
      case ($urandom_range(0, 4))
        0:       write_register(REG_SPEED_NUMERATOR, 32'hFFFF_FFFF);
        1:       write_register(REG_SPEED_NUMERATOR, 32'd0);
        default: write_register(REG_SPEED_NUMERATOR, $urandom >> $urandom_range(0, 31));
      endcase
      if ($urandom_range(0, 3) == 0) write_register(REG_SPARE, $urandom);

      // one phase runs into the long receiver hold-off while still sending
      if (phase == 2) hold_request = 1'b1;

      tick_pct = $urandom_range(10, 70);
      n        = $urandom_range(80, 160);
      repeat (n) begin
        m = ($urandom_range(1, 100) <= tick_pct) ? MODE_TICK : MODE_EDGE;
        offer_request(m, CHAN_BITS'($urandom_range(0, 3)), 1'b0, blank);
        pace_sender();
        random_sent++;
      end
      phase++;
    end

    item_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("encoder_period_speed_meter test passed");
    end else begin
      $display("encoder_period_speed_meter test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/epsm_pkg.sv
rtl/core/epsm_item_if.sv
rtl/core/epsm_result_if.sv
rtl/core/epsm_cfg_if.sv
rtl/core/encoder_period_speed_meter.sv
tb/tb_encoder_period_speed_meter.sv
